@@ design/accel_dead_reckoning_distance_unit_assert.svh @@
// Assertion macros used by the sequencer of the dead-reckoning distance unit
`ifndef ACCEL_DEAD_RECKONING_DISTANCE_UNIT_ASSERT_SVH
`define ACCEL_DEAD_RECKONING_DISTANCE_UNIT_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define ADRD_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("adrd: same-cycle check failed");

// next-cycle implication, clocked on clk, off during reset
`define ADRD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("adrd: next-cycle check failed");

`endif

@@ design/adrd_pkg.sv @@
// Types, constants and codes for the dead-reckoning distance unit
`default_nettype none

package adrd_pkg;

  // sample acceptance limits
  localparam int MAX_DT_MS    = 100;
  localparam int DEADZONE_LSB = 102;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int UNIT_W     = 10;
  localparam int UNIT_RESET = 50;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TRACKING,
    CFG_OFFSET_X,
    CFG_OFFSET_Y,
    CFG_UNIT_MM
  } cfg_idx_t;

  // datapath widths
  localparam int VEL_W  = 40;
  localparam int POS_W  = 48;
  localparam int ACC_W  = 56;
  localparam int MUL_AW = 24;
  localparam int MUL_BW = 16;
  localparam int MUL_PW = MUL_AW + MUL_BW;
  localparam int MAG_W  = 24;

  // 0.95 in Q0.16 and the half-LSB for rounding off 16 fraction bits
  localparam int DAMP_Q16  = 62259;
  localparam int ROUND_Q16 = 32768;

  // v*dt*8/250 gives the Q16.16 mm step; 125 rounds it
  localparam int CDIV_W       = 56;
  localparam int CDIV_DIVISOR = 250;
  localparam int CDIV_BIAS    = 125;
  localparam int CDIV_REM_W   = 8;
  localparam int CDIV_BITS    = 8;
  localparam int CDIV_STEPS   = CDIV_W / CDIV_BITS;

  // square root of mx^2 + my^2, one result bit per cycle
  localparam int SQ_W       = 49;
  localparam int SQRT_STEPS = (SQ_W + 1) / 2;
  localparam int ROOT_W     = SQRT_STEPS;

  // unit divider: (2T + u) / 2u
  localparam int UD_W     = 18;
  localparam int UD_D_W   = UNIT_W + 1;
  localparam int UD_BITS  = 2;
  localparam int UD_STEPS = UD_W / UD_BITS;

  localparam int CNT_W = $clog2(SQRT_STEPS);

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_ADIFF,
    ST_AMUL,
    ST_VSUM,
    ST_VMAG,
    ST_DMUL_LO,
    ST_DMUL_HI,
    ST_DROUND,
    ST_PMUL_LO,
    ST_PMUL_HI,
    ST_CDIV_LOAD,
    ST_CDIV,
    ST_PSUM,
    ST_PMAG,
    ST_SQX_LO,
    ST_SQX_HI,
    ST_SQY_LO,
    ST_SQY_HI,
    ST_SQRT_LOAD,
    ST_SQRT,
    ST_TOTAL,
    ST_UDIV_LOAD,
    ST_UDIV,
    ST_DONE
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_CLEAR,
    OP_ADIFF,
    OP_AMUL,
    OP_VSUM,
    OP_VMAG,
    OP_DMUL_LO,
    OP_DMUL_HI,
    OP_DROUND,
    OP_PMUL_LO,
    OP_PMUL_HI,
    OP_CDIV_LOAD,
    OP_CDIV,
    OP_PSUM,
    OP_PMAG,
    OP_SQX_LO,
    OP_SQX_HI,
    OP_SQY_LO,
    OP_SQY_HI,
    OP_SQRT_LOAD,
    OP_SQRT,
    OP_TOTAL,
    OP_UDIV_LOAD,
    OP_UDIV,
    OP_OUT
  } op_t;

  typedef struct packed {
    op_t  op;
    logic axis;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_req;
    logic sample_ok;
  } dp_stat_t;

endpackage

`default_nettype wire

@@ design/adrd_ctrl.sv @@
// Sequencer for the dead-reckoning distance unit
`default_nettype none
`include "accel_dead_reckoning_distance_unit_assert.svh"

module adrd_ctrl import adrd_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t dp_stat,
  output dp_cmd_t  dp_cmd
);

  state_t           state, state_next;
  logic             axis, axis_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic             out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      axis      <= 1'b0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      axis      <= axis_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next  = state;
    axis_next   = axis;
    cnt_next    = cnt;
    in_ready    = 1'b0;
    dp_cmd.op   = OP_NONE;
    dp_cmd.axis = axis;
    unique case (state)
      ST_IDLE: begin
        in_ready = !rst;
        if (in_valid && !rst) begin
          dp_cmd.op  = OP_LOAD;
          state_next = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        axis_next = 1'b0;
        if (dp_stat.clear_req) begin
          dp_cmd.op  = OP_CLEAR;
          state_next = ST_UDIV_LOAD;
        end else if (dp_stat.sample_ok) begin
          state_next = ST_ADIFF;
        end else begin
          state_next = ST_UDIV_LOAD;
        end
      end
      ST_ADIFF: begin
        dp_cmd.op  = OP_ADIFF;
        state_next = ST_AMUL;
      end
      ST_AMUL: begin
        dp_cmd.op  = OP_AMUL;
        state_next = ST_VSUM;
      end
      ST_VSUM: begin
        dp_cmd.op  = OP_VSUM;
        state_next = ST_VMAG;
      end
      ST_VMAG: begin
        dp_cmd.op  = OP_VMAG;
        state_next = ST_DMUL_LO;
      end
      ST_DMUL_LO: begin
        dp_cmd.op  = OP_DMUL_LO;
        state_next = ST_DMUL_HI;
      end
      ST_DMUL_HI: begin
        dp_cmd.op  = OP_DMUL_HI;
        state_next = ST_DROUND;
      end
      ST_DROUND: begin
        dp_cmd.op  = OP_DROUND;
        state_next = ST_PMUL_LO;
      end
      ST_PMUL_LO: begin
        dp_cmd.op  = OP_PMUL_LO;
        state_next = ST_PMUL_HI;
      end
      ST_PMUL_HI: begin
        dp_cmd.op  = OP_PMUL_HI;
        state_next = ST_CDIV_LOAD;
      end
      ST_CDIV_LOAD: begin
        dp_cmd.op  = OP_CDIV_LOAD;
        cnt_next   = '0;
        state_next = ST_CDIV;
      end
      ST_CDIV: begin
        dp_cmd.op = OP_CDIV;
        cnt_next  = cnt + CNT_W'(1);
        if (cnt == CNT_W'(CDIV_STEPS - 1)) begin
          state_next = ST_PSUM;
        end
      end
      ST_PSUM: begin
        dp_cmd.op = OP_PSUM;
        if (!axis) begin
          axis_next  = 1'b1;
          state_next = ST_ADIFF;
        end else begin
          state_next = ST_PMAG;
        end
      end
      ST_PMAG: begin
        dp_cmd.op  = OP_PMAG;
        state_next = ST_SQX_LO;
      end
      ST_SQX_LO: begin
        dp_cmd.op  = OP_SQX_LO;
        state_next = ST_SQX_HI;
      end
      ST_SQX_HI: begin
        dp_cmd.op  = OP_SQX_HI;
        state_next = ST_SQY_LO;
      end
      ST_SQY_LO: begin
        dp_cmd.op  = OP_SQY_LO;
        state_next = ST_SQY_HI;
      end
      ST_SQY_HI: begin
        dp_cmd.op  = OP_SQY_HI;
        state_next = ST_SQRT_LOAD;
      end
      ST_SQRT_LOAD: begin
        dp_cmd.op  = OP_SQRT_LOAD;
        cnt_next   = '0;
        state_next = ST_SQRT;
      end
      ST_SQRT: begin
        dp_cmd.op = OP_SQRT;
        cnt_next  = cnt + CNT_W'(1);
        if (cnt == CNT_W'(SQRT_STEPS - 1)) begin
          state_next = ST_TOTAL;
        end
      end
      ST_TOTAL: begin
        dp_cmd.op  = OP_TOTAL;
        state_next = ST_UDIV_LOAD;
      end
      ST_UDIV_LOAD: begin
        dp_cmd.op  = OP_UDIV_LOAD;
        cnt_next   = '0;
        state_next = ST_UDIV;
      end
      ST_UDIV: begin
        dp_cmd.op = OP_UDIV;
        cnt_next  = cnt + CNT_W'(1);
        if (cnt == CNT_W'(UD_STEPS - 1)) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        // hold here while the previous result is still unread
        if (!out_valid || out_ready) begin
          dp_cmd.op  = OP_OUT;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign out_valid_next = (dp_cmd.op == OP_OUT) || (out_valid && !out_ready);

  `ADRD_ASSERT_SAME(a_no_result_overwrite, dp_cmd.op == OP_OUT, !out_valid || out_ready)
  `ADRD_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  `ADRD_ASSERT_SAME(a_result_from_done, $rose(out_valid), $past(state == ST_DONE))
  `ADRD_ASSERT_SAME(a_loop_count_bound, state == ST_SQRT, cnt < CNT_W'(SQRT_STEPS))

endmodule

`default_nettype wire

@@ design/adrd_dp.sv @@
// Datapath: configuration, integrators, shared multiplier, dividers and square root
`default_nettype none

module adrd_dp import adrd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  cmd,
  input  logic signed [15:0]    accel_x,
  input  logic signed [15:0]    accel_y,
  input  logic [15:0]           elapsed_ms,
  input  dp_cmd_t               dp_cmd,
  output dp_stat_t              dp_stat,
  output logic signed [15:0]    dist_x_mm,
  output logic signed [15:0]    dist_y_mm,
  output logic [15:0]           total_mm,
  output logic [15:0]           total_units,
  output logic                  sample_used
);

  // configuration
  logic              tracking_enable;
  logic [15:0]       offset_x;
  logic [15:0]       offset_y;
  logic [UNIT_W-1:0] unit_mm;

  // integrator state
  logic [VEL_W-1:0] vel [2];
  logic [POS_W-1:0] pos [2];
  logic [15:0]      total_dist;

  // latched request
  logic        item_clear;
  logic [15:0] item_ax;
  logic [15:0] item_ay;
  logic [15:0] item_dt;
  logic        used;

  // working registers
  logic [15:0]         amag;
  logic                aneg;
  logic [VEL_W-1:0]    vmag;
  logic                vneg;
  logic [ACC_W-1:0]    acc;
  logic [CDIV_W-1:0]   cd_num;
  logic [CDIV_REM_W-1:0] cd_rem;
  logic [MAG_W-1:0]    mx;
  logic [MAG_W-1:0]    my;
  logic                p_ovf;
  logic [SQ_W-1:0]     sq_n;
  logic [SQ_W-1:0]     sq_res;
  logic [SQ_W-1:0]     sq_bit;
  logic [UD_W-1:0]     ud_num;
  logic [UD_D_W-1:0]   ud_rem;

  function automatic logic [15:0] mm_round(input logic [POS_W-1:0] p);
    logic [POS_W:0]    s;
    logic [POS_W-16:0] r;
    // half away from zero: add 0.5 LSB, one less on the negative side
    s = {p[POS_W-1], p} + (p[POS_W-1] ? (POS_W+1)'(ROUND_Q16 - 1) : (POS_W+1)'(ROUND_Q16));
    r = s[POS_W:16];
    if (!r[POS_W-16] && (|r[POS_W-17:15])) begin
      mm_round = 16'h7FFF;
    end else if (r[POS_W-16] && !(&r[POS_W-17:15])) begin
      mm_round = 16'h8000;
    end else begin
      mm_round = r[15:0];
    end
  endfunction

  assign dp_stat.clear_req = item_clear;
  assign dp_stat.sample_ok = tracking_enable && (item_dt != 16'd0) &&
                             (item_dt <= 16'(MAX_DT_MS));

  // acceleration after offset and dead zone
  logic [15:0] sel_accel, sel_off;
  logic [16:0] adiff, adiff_mag;
  logic        a_dead;

  assign sel_accel = dp_cmd.axis ? item_ay : item_ax;
  assign sel_off   = dp_cmd.axis ? offset_y : offset_x;
  assign adiff     = {sel_accel[15], sel_accel} - {sel_off[15], sel_off};
  assign adiff_mag = adiff[16] ? (17'd0 - adiff) : adiff;
  assign a_dead    = adiff_mag <= 17'(DEADZONE_LSB);

  // shared 24x16 multiplier with shifted accumulate
  logic [MUL_AW-1:0] mul_a;
  logic [MUL_BW-1:0] mul_b;
  logic [4:0]        mul_sh;
  logic              mul_acc;
  logic [MUL_PW-1:0] mul_p;
  logic [ACC_W-1:0]  mul_term, acc_sum;

  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    mul_sh  = 5'd0;
    mul_acc = 1'b0;
    unique case (dp_cmd.op)
      OP_AMUL: begin
        mul_a = MUL_AW'(amag);
        mul_b = item_dt;
      end
      OP_DMUL_LO: begin
        mul_a = vmag[MUL_AW-1:0];
        mul_b = MUL_BW'(DAMP_Q16);
      end
      OP_DMUL_HI: begin
        mul_a   = MUL_AW'(vmag[VEL_W-1:MUL_AW]);
        mul_b   = MUL_BW'(DAMP_Q16);
        mul_sh  = 5'(MUL_AW);
        mul_acc = 1'b1;
      end
      OP_PMUL_LO: begin
        mul_a = vmag[MUL_AW-1:0];
        mul_b = item_dt;
      end
      OP_PMUL_HI: begin
        mul_a   = MUL_AW'(vmag[VEL_W-1:MUL_AW]);
        mul_b   = item_dt;
        mul_sh  = 5'(MUL_AW);
        mul_acc = 1'b1;
      end
      OP_SQX_LO: begin
        mul_a = mx;
        mul_b = mx[15:0];
      end
      OP_SQX_HI: begin
        mul_a   = mx;
        mul_b   = MUL_BW'(mx[MAG_W-1:16]);
        mul_sh  = 5'd16;
        mul_acc = 1'b1;
      end
      OP_SQY_LO: begin
        mul_a   = my;
        mul_b   = my[15:0];
        mul_acc = 1'b1;
      end
      OP_SQY_HI: begin
        mul_a   = my;
        mul_b   = MUL_BW'(my[MAG_W-1:16]);
        mul_sh  = 5'd16;
        mul_acc = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign mul_p    = MUL_PW'(mul_a) * MUL_PW'(mul_b);
  assign mul_term = ACC_W'(mul_p) << mul_sh;
  assign acc_sum  = (mul_acc ? acc : '0) + mul_term;

  // velocity update with saturation
  logic [VEL_W-1:0] vel_sel;
  logic [VEL_W:0]   v_delta, vsum;
  logic [VEL_W-1:0] vel_sat;

  assign vel_sel = vel[dp_cmd.axis];
  assign v_delta = aneg ? ((VEL_W+1)'(0) - (VEL_W+1)'(acc[31:0])) : (VEL_W+1)'(acc[31:0]);
  assign vsum    = {vel_sel[VEL_W-1], vel_sel} + v_delta;
  assign vel_sat = (vsum[VEL_W] != vsum[VEL_W-1]) ?
                   (vsum[VEL_W] ? {1'b1, {(VEL_W-1){1'b0}}} : {1'b0, {(VEL_W-1){1'b1}}}) :
                   vsum[VEL_W-1:0];

  logic [ACC_W-1:0] acc_round;
  assign acc_round = acc + ACC_W'(ROUND_Q16);

  // position update with saturation
  logic [POS_W-1:0] pos_sel;
  logic [POS_W:0]   p_step, psum;
  logic [POS_W-1:0] pos_sat;

  assign pos_sel = pos[dp_cmd.axis];
  assign p_step  = vneg ? ((POS_W+1)'(0) - {1'b0, cd_num[POS_W-1:0]}) :
                          {1'b0, cd_num[POS_W-1:0]};
  assign psum    = {pos_sel[POS_W-1], pos_sel} + p_step;
  assign pos_sat = (psum[POS_W] != psum[POS_W-1]) ?
                   (psum[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}}) :
                   psum[POS_W-1:0];

  logic [POS_W-1:0] pmag_x, pmag_y;
  assign pmag_x = pos[0][POS_W-1] ? (POS_W'(0) - pos[0]) : pos[0];
  assign pmag_y = pos[1][POS_W-1] ? (POS_W'(0) - pos[1]) : pos[1];

  // divide by 250, eight quotient bits per cycle
  logic [CDIV_W-1:0]     cd_num_next;
  logic [CDIV_REM_W-1:0] cd_rem_next;

  always_comb begin
    logic [CDIV_REM_W:0] r;
    cd_num_next = cd_num;
    cd_rem_next = cd_rem;
    for (int i = 0; i < CDIV_BITS; i++) begin
      r           = {cd_rem_next, cd_num_next[CDIV_W-1]};
      cd_num_next = {cd_num_next[CDIV_W-2:0], 1'b0};
      if (r >= (CDIV_REM_W+1)'(CDIV_DIVISOR)) begin
        r              = r - (CDIV_REM_W+1)'(CDIV_DIVISOR);
        cd_num_next[0] = 1'b1;
      end
      cd_rem_next = r[CDIV_REM_W-1:0];
    end
  end

  // square root step: res and bit never overlap, so OR forms their sum
  logic [SQ_W-1:0] sq_trial;
  assign sq_trial = sq_res | sq_bit;

  logic [ROOT_W:0] root_rnd;
  assign root_rnd = {1'b0, sq_res[ROOT_W-1:0]} + (ROOT_W+1)'(128);

  // unit divider, two quotient bits per cycle
  logic [UNIT_W-1:0] unit_eff;
  logic [UD_D_W-1:0] ud_div;
  logic [UD_W-1:0]   ud_num_next;
  logic [UD_D_W-1:0] ud_rem_next;

  assign unit_eff = (unit_mm == '0) ? UNIT_W'(1) : unit_mm;
  assign ud_div   = {unit_eff, 1'b0};

  always_comb begin
    logic [UD_D_W:0] r;
    ud_num_next = ud_num;
    ud_rem_next = ud_rem;
    for (int i = 0; i < UD_BITS; i++) begin
      r           = {ud_rem_next, ud_num_next[UD_W-1]};
      ud_num_next = {ud_num_next[UD_W-2:0], 1'b0};
      if (r >= {1'b0, ud_div}) begin
        r              = r - {1'b0, ud_div};
        ud_num_next[0] = 1'b1;
      end
      ud_rem_next = r[UD_D_W-1:0];
    end
  end

  // configuration and integrator state
  always_ff @(posedge clk) begin
    if (rst) begin
      tracking_enable <= 1'b0;
      offset_x        <= '0;
      offset_y        <= '0;
      unit_mm         <= UNIT_W'(UNIT_RESET);
      vel[0]          <= '0;
      vel[1]          <= '0;
      pos[0]          <= '0;
      pos[1]          <= '0;
      total_dist      <= '0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_TRACKING: tracking_enable <= cfg_data[0];
          CFG_OFFSET_X: offset_x        <= cfg_data;
          CFG_OFFSET_Y: offset_y        <= cfg_data;
          CFG_UNIT_MM:  unit_mm         <= cfg_data[UNIT_W-1:0];
        endcase
      end
      unique case (dp_cmd.op)
        OP_CLEAR: begin
          vel[0]     <= '0;
          vel[1]     <= '0;
          pos[0]     <= '0;
          pos[1]     <= '0;
          total_dist <= '0;
        end
        OP_VSUM: vel[dp_cmd.axis] <= vel_sat;
        OP_PMUL_LO: vel[dp_cmd.axis] <= vneg ? (VEL_W'(0) - vmag) : vmag;
        OP_PSUM: pos[dp_cmd.axis] <= pos_sat;
        OP_TOTAL: begin
          if (p_ovf || (|root_rnd[ROOT_W:24])) begin
            total_dist <= 16'hFFFF;
          end else begin
            total_dist <= root_rnd[23:8];
          end
        end
        default: begin
        end
      endcase
    end
  end

  // working registers and result
  always_ff @(posedge clk) begin
    unique case (dp_cmd.op)
      OP_LOAD: begin
        item_clear <= cmd;
        item_ax    <= accel_x;
        item_ay    <= accel_y;
        item_dt    <= elapsed_ms;
        used       <= 1'b0;
      end
      OP_ADIFF: begin
        amag <= a_dead ? 16'd0 : adiff_mag[15:0];
        aneg <= adiff[16];
      end
      OP_AMUL, OP_DMUL_LO, OP_DMUL_HI, OP_PMUL_LO, OP_PMUL_HI,
      OP_SQX_LO, OP_SQX_HI, OP_SQY_LO, OP_SQY_HI: begin
        acc <= acc_sum;
      end
      OP_VMAG: begin
        vmag <= vel_sel[VEL_W-1] ? (VEL_W'(0) - vel_sel) : vel_sel;
        vneg <= vel_sel[VEL_W-1];
      end
      OP_DROUND: vmag <= acc_round[ACC_W-1:16];
      OP_CDIV_LOAD: begin
        cd_num <= {acc[CDIV_W-4:0], 3'b000} + CDIV_W'(CDIV_BIAS);
        cd_rem <= '0;
      end
      OP_CDIV: begin
        cd_num <= cd_num_next;
        cd_rem <= cd_rem_next;
      end
      OP_PMAG: begin
        mx    <= pmag_x[MAG_W+7:8];
        my    <= pmag_y[MAG_W+7:8];
        p_ovf <= (|pmag_x[POS_W-1:32]) || (|pmag_y[POS_W-1:32]);
      end
      OP_SQRT_LOAD: begin
        sq_n   <= acc[SQ_W-1:0];
        sq_res <= '0;
        sq_bit <= {1'b1, {(SQ_W-1){1'b0}}};
      end
      OP_SQRT: begin
        if (sq_n >= sq_trial) begin
          sq_n   <= sq_n - sq_trial;
          sq_res <= (sq_res >> 1) | sq_bit;
        end else begin
          sq_res <= sq_res >> 1;
        end
        sq_bit <= sq_bit >> 2;
      end
      OP_TOTAL: used <= 1'b1;
      OP_UDIV_LOAD: begin
        ud_num <= {1'b0, total_dist, 1'b0} + UD_W'(unit_eff);
        ud_rem <= '0;
      end
      OP_UDIV: begin
        ud_num <= ud_num_next;
        ud_rem <= ud_rem_next;
      end
      OP_OUT: begin
        dist_x_mm   <= mm_round(pos[0]);
        dist_y_mm   <= mm_round(pos[1]);
        total_mm    <= total_dist;
        total_units <= ud_num[15:0];
        sample_used <= used;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

@@ design/accel_dead_reckoning_distance_unit.sv @@
// Top level of the accelerometer dead-reckoning distance unit
//
// Channel  | Handshake                 | Payload
// ---------+---------------------------+----------------------------------------------
// request  | in_valid / in_ready       | cmd, accel_x, accel_y, elapsed_ms
// result   | out_valid / out_ready     | dist_x_mm, dist_y_mm, total_mm, total_units,
//          |                           | sample_used
// config   | cfg_wr_en                 | cfg_index, cfg_data
//
// A request that updates the integrators runs each axis through the shared 24x16
// multiplier and the divide by 250 at eight bits a cycle, then the 25-step square
// root and the unit divider at two bits a cycle; a clear or an ignored sample goes
// straight to the unit divider. No new request is accepted until the last is done.
// Synchronous reset zeroes the integrators, loads the register defaults and
// empties the result channel. A result sits in the output registers until taken;
// the next request is accepted meanwhile and waits at its end if still unread.
`default_nettype none

module accel_dead_reckoning_distance_unit import adrd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  cmd,
  input  logic signed [15:0]    accel_x,
  input  logic signed [15:0]    accel_y,
  input  logic [15:0]           elapsed_ms,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic signed [15:0]    dist_x_mm,
  output logic signed [15:0]    dist_y_mm,
  output logic [15:0]           total_mm,
  output logic [15:0]           total_units,
  output logic                  sample_used
);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  adrd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .dp_stat   (dp_stat),
    .dp_cmd    (dp_cmd)
  );

  adrd_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .cmd         (cmd),
    .accel_x     (accel_x),
    .accel_y     (accel_y),
    .elapsed_ms  (elapsed_ms),
    .dp_cmd      (dp_cmd),
    .dp_stat     (dp_stat),
    .dist_x_mm   (dist_x_mm),
    .dist_y_mm   (dist_y_mm),
    .total_mm    (total_mm),
    .total_units (total_units),
    .sample_used (sample_used)
  );

endmodule

`default_nettype wire
